/* rtl/char_lcd_nibble_write_sequencer_core_macros.svh */
// Assertion macros for the character LCD nibble write sequencer.
// Included by the checker module; needs clk and arst_n in scope.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is low
`define LCDSEQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcd sequencer: same-cycle check failed");

// Next-cycle implication, masked while reset is low
`define LCDSEQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcd sequencer: next-cycle check failed");

`endif

/* rtl/lcdseq_pkg.sv */
// Shared types and constants of the LCD nibble write sequencer:
// command and register codes, control word layout and the microcode ROM.
// No dependencies.
package lcdseq_pkg;

	// Command codes (item kind on the input side)
	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_INSTR  = 2'd1;
	localparam logic [1:0] CMD_DATA   = 2'd2;
	localparam logic [1:0] CMD_CURSOR = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_POWER_UP = 2'd0;
	localparam logic [1:0] CFG_WRITE    = 2'd1;
	localparam logic [1:0] CFG_CLEAR    = 2'd2;

	localparam int PWR_W  = 16;
	localparam int WR_W   = 12;
	localparam int CLR_W  = 18;
	localparam int WAIT_W = 19;
	localparam int CFG_W  = 18;
	localparam int PC_W   = 4;

	localparam logic [PWR_W-1:0] POWER_UP_RST = 16'd20000;
	localparam logic [WR_W-1:0]  WRITE_RST    = 12'd500;
	localparam logic [CLR_W-1:0] CLEAR_RST    = 18'd100000;

	localparam logic [WAIT_W-1:0] WAIT_10K = 19'd10000;
	localparam logic [WAIT_W-1:0] WAIT_1K  = 19'd1000;

	// Program entry points
	localparam logic [PC_W-1:0] PC_INIT = 4'd0;
	localparam logic [PC_W-1:0] PC_BYTE = 4'd13;

	// Cursor address prefixes for top and bottom line
	localparam logic [1:0] DDRAM_LINE0 = 2'b10;
	localparam logic [1:0] DDRAM_LINE1 = 2'b11;

	typedef enum logic [1:0] {
		NS_CONST,
		NS_HI,
		NS_LO
	} nib_sel_t;

	typedef enum logic [2:0] {
		WS_ZERO,
		WS_POWER_UP,
		WS_10K,
		WS_1K,
		WS_WRITE,
		WS_CLEAR
	} wait_sel_t;

	// One control word per bus event
	typedef struct packed {
		nib_sel_t  nsel;
		logic [3:0] nib;
		logic       en;
		wait_sel_t wsel;
		logic       stop;
	} cw_t;

	function automatic cw_t mk(input nib_sel_t s, input logic [3:0] n, input logic e,
			input wait_sel_t w, input logic st);
		cw_t c;
		c.nsel = s;
		c.nib  = n;
		c.en   = e;
		c.wsel = w;
		c.stop = st;
		return c;
	endfunction

	// Microcode ROM: init program, then the shared byte-write program
	function automatic cw_t ucode(input logic [PC_W-1:0] pc);
		cw_t c;
		case (pc)
			4'd0:    c = mk(NS_CONST, 4'h0, 1'b0, WS_POWER_UP, 1'b0);
			4'd1:    c = mk(NS_CONST, 4'h3, 1'b1, WS_10K,      1'b0);
			4'd2:    c = mk(NS_CONST, 4'h3, 1'b1, WS_1K,       1'b0);
			4'd3:    c = mk(NS_CONST, 4'h3, 1'b1, WS_1K,       1'b0);
			4'd4:    c = mk(NS_CONST, 4'h2, 1'b1, WS_1K,       1'b0);
			4'd5:    c = mk(NS_CONST, 4'h0, 1'b1, WS_ZERO,     1'b0); // entry mode 06h
			4'd6:    c = mk(NS_CONST, 4'h6, 1'b1, WS_WRITE,    1'b0);
			4'd7:    c = mk(NS_CONST, 4'h2, 1'b1, WS_ZERO,     1'b0); // function set 28h
			4'd8:    c = mk(NS_CONST, 4'h8, 1'b1, WS_WRITE,    1'b0);
			4'd9:    c = mk(NS_CONST, 4'h0, 1'b1, WS_ZERO,     1'b0); // display on 0Ch
			4'd10:   c = mk(NS_CONST, 4'hC, 1'b1, WS_WRITE,    1'b0);
			4'd11:   c = mk(NS_CONST, 4'h0, 1'b1, WS_ZERO,     1'b0); // clear 01h
			4'd12:   c = mk(NS_CONST, 4'h1, 1'b1, WS_CLEAR,    1'b1);
			4'd13:   c = mk(NS_HI,    4'h0, 1'b1, WS_ZERO,     1'b0);
			4'd14:   c = mk(NS_LO,    4'h0, 1'b1, WS_WRITE,    1'b1);
			default: c = mk(NS_CONST, 4'h0, 1'b0, WS_ZERO,     1'b1);
		endcase
		return c;
	endfunction

endpackage

/* rtl/char_lcd_nibble_write_sequencer_core.sv */
// The first bus event of a command is registered: accept loads the run state and step counter,
// and the event then enters the output register once that register is free. Initialise emits
// 13 events and a byte command 2; the step counter emits one event per cycle unless stalled.
// s_tready is low while a program runs; the output register frees the sink side.
// Reset (arst_n low, asynchronous): idle, no output item, registers at their defaults.
// Top level of the LCD nibble write sequencer; uses lcdseq_pkg.
module char_lcd_nibble_write_sequencer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [lcdseq_pkg::CFG_W-1:0] cfg_data,
	// command input
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // byte_value[7:0], line[8], column[14:9]
	input  logic [1:0]                   s_tuser,  // command[1:0]
	// bus event output
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,  // nibble[3:0], enable_pulse[4],
	                                               // wait_after_us[23:5]
	output logic                         m_tuser,  // register_select
	output logic                         m_tlast   // last event of the command
);
	import lcdseq_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic [7:0]        byte_q;
	logic              rs_q;
	logic [PWR_W-1:0]  pwr_q;
	logic [WR_W-1:0]   wr_q;
	logic [CLR_W-1:0]  clr_q;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;
	logic              m_tuser_q;
	logic              m_tlast_q;

	cw_t               cw;
	logic              accept;
	logic              emit;
	logic [3:0]        nib;
	logic [WAIT_W-1:0] wait_us;
	logic [7:0]        in_byte;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_q <= POWER_UP_RST;
			wr_q  <= WRITE_RST;
			clr_q <= CLEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POWER_UP: pwr_q <= cfg_data[PWR_W-1:0];
				CFG_WRITE:    wr_q  <= cfg_data[WR_W-1:0];
				CFG_CLEAR:    clr_q <= cfg_data[CLR_W-1:0];
				default:      ;
			endcase
		end
	end

	// Fetch the control word of the current step
	assign cw     = ucode(pc_q);
	assign accept = s_tvalid && s_tready;
	assign emit   = (state_q == ST_RUN) && (!m_tvalid_q || m_tready);

	// Byte to send: the input byte, or the DDRAM address for a cursor move
	always_comb begin
		case (s_tuser)
			CMD_CURSOR: in_byte = {(s_tdata[8] ? DDRAM_LINE1 : DDRAM_LINE0), s_tdata[14:9]};
			default:    in_byte = s_tdata[7:0];
		endcase
	end

	// Datapath: nibble select
	always_comb begin
		case (cw.nsel)
			NS_HI:   nib = byte_q[7:4];
			NS_LO:   nib = byte_q[3:0];
			default: nib = cw.nib;
		endcase
	end

	// Datapath: wait select
	always_comb begin
		case (cw.wsel)
			WS_POWER_UP: wait_us = {{(WAIT_W-PWR_W){1'b0}}, pwr_q};
			WS_10K:      wait_us = WAIT_10K;
			WS_1K:       wait_us = WAIT_1K;
			WS_WRITE:    wait_us = {{(WAIT_W-WR_W){1'b0}}, wr_q};
			WS_CLEAR:    wait_us = {{(WAIT_W-WR_W){1'b0}}, wr_q}
			                     + {{(WAIT_W-CLR_W){1'b0}}, clr_q};
			default:     wait_us = '0;
		endcase
	end

	// Sequencer state, step counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= PC_INIT;
			byte_q     <= '0;
			rs_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= ST_RUN;
				pc_q    <= (s_tuser == CMD_INIT) ? PC_INIT : PC_BYTE;
				byte_q  <= in_byte;
				rs_q    <= (s_tuser == CMD_DATA);
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {wait_us, cw.en, nib};
				m_tuser_q  <= rs_q;
				m_tlast_q  <= cw.stop;
				pc_q       <= pc_q + 1'b1;
				if (cw.stop) begin
					state_q <= ST_IDLE;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* rtl/lcdseq_chk.sv */
// Port-level checker of the LCD nibble write sequencer, bound to the top level.
// Uses the assertion macros header.
`include "char_lcd_nibble_write_sequencer_core_macros.svh"

module lcdseq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled output item holds
	`LCDSEQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// An accepted command starts a run, so no second command the next cycle
	`LCDSEQ_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// A pure wait event drives nibble zero to the instruction register
	`LCDSEQ_ASSERT_IMP(a_pure_wait, m_tvalid && !m_tdata[4], (m_tdata[3:0] == 4'h0) && !m_tuser)

	// Data register events and final events always strobe enable
	`LCDSEQ_ASSERT_IMP(a_strobe, m_tvalid && (m_tuser || m_tlast), m_tdata[4])

endmodule

bind char_lcd_nibble_write_sequencer_core lcdseq_chk u_lcdseq_chk (.*);
